FILE: hw/rtl/key_fob_frame_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// key fob frame decoder assertion macros
// concurrent assertion forms used by the decoder's job queue
// ----------------------------------------------------------------------------
`ifndef KEY_FOB_FRAME_DECODER_TOP_DEFINES_SVH
`define KEY_FOB_FRAME_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define KFFD_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KFFD_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/kffd_pkg.sv
// ----------------------------------------------------------------------------
// kffd_pkg
// types and constants shared by the key fob frame decoder
// ----------------------------------------------------------------------------
package kffd_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_LEN_ABORT = 2'd1,
    STATUS_SANITY    = 2'd2
  } status_t;

  localparam logic [7:0] PRE_LEN_LONG   = 8'd35;
  localparam logic [7:0] PRE_LEN_SHORT  = 8'd28;
  localparam logic [7:0] DATA_LEN_SHORT = 8'd167;
  localparam logic [7:0] DATA_LEN_LONG  = 8'd168;

  localparam logic [7:0] PRE0_VAL_A = 8'hFF;
  localparam logic [7:0] PRE0_VAL_B = 8'h99;
  localparam logic [7:0] PRE1_VAL_A = 8'h33;
  localparam logic [7:0] PRE1_VAL_B = 8'h99;

  localparam logic [4:0] POS_MAX      = 5'd31;
  localparam logic [4:0] POS_KEY_END  = 5'd16;
  localparam logic [4:0] POS_CHK_END  = 5'd20;
  localparam logic [4:0] POS_LAST_MIN = 5'd19;

  localparam logic [1:0] SYM_ONE  = 2'b01;
  localparam logic [1:0] SYM_ZERO = 2'b10;

  typedef struct packed {
    status_t     status;
    logic [63:0] key_word;
    logic [15:0] check_word;
  } job_t;

endpackage

FILE: hw/rtl/kffd_if.sv
// ----------------------------------------------------------------------------
// kffd channel interfaces
// valid/ready channels for row bytes and decoded frames
// ----------------------------------------------------------------------------
interface kffd_in_if;
  logic       valid;
  logic       ready;
  logic       row_select;
  logic [7:0] row_length_bits;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, row_select, row_length_bits, data_byte, last_byte,
                  input ready);
  modport sink   (input valid, row_select, row_length_bits, data_byte, last_byte,
                  output ready);
endinterface

interface kffd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] key_word;
  logic [7:0]  bs_byte;
  logic [7:0]  crc_byte;
  logic [31:0] serial_number;
  logic [3:0]  button_code;
  logic [19:0] rolling_count;

  modport source (output valid, status, key_word, bs_byte, crc_byte, serial_number,
                  button_code, rolling_count, input ready);
  modport sink   (input valid, status, key_word, bs_byte, crc_byte, serial_number,
                  button_code, rolling_count, output ready);
endinterface

FILE: hw/rtl/kffd_front.sv
// ----------------------------------------------------------------------------
// kffd_front
// takes row bytes, decodes symbols, tracks faults, emits one job per data row
// ----------------------------------------------------------------------------
module kffd_front import kffd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  kffd_in_if.sink    in_ch,
  output logic       push_valid,
  input  logic       push_ready,
  output job_t       push_data
);

  logic [63:0] key_r,  key_nxt;
  logic [15:0] chk_r,  chk_nxt;
  logic [4:0]  pos_r,  pos_nxt;
  logic        sym_fault_r, sym_fault_nxt;
  logic        pre_len_fault_r, pre_len_fault_nxt;
  logic        pre_val_fault_r, pre_val_fault_nxt;

  logic        fire;
  logic [3:0]  bits;
  logic        bad_sym;
  logic [1:0]  sym;
  logic [63:0] key_base;
  logic [15:0] chk_base;
  logic        len_ok;

  assign fire        = in_ch.valid && in_ch.ready;
  assign in_ch.ready = push_ready;

  always_comb begin
    bad_sym = 1'b0;
    bits    = '0;
    sym     = '0;
    for (int s = 0; s < 4; s++) begin
      sym     = in_ch.data_byte[2*s +: 2];
      bits[s] = (sym == SYM_ONE);
      if (sym != SYM_ONE && sym != SYM_ZERO) bad_sym = 1'b1;
    end
  end

  always_comb begin
    key_nxt           = key_r;
    chk_nxt           = chk_r;
    pos_nxt           = pos_r;
    sym_fault_nxt     = sym_fault_r;
    pre_len_fault_nxt = pre_len_fault_r;
    pre_val_fault_nxt = pre_val_fault_r;
    key_base          = key_r;
    chk_base          = chk_r;
    push_valid        = 1'b0;
    push_data         = '0;
    len_ok = (in_ch.row_length_bits == DATA_LEN_SHORT) ||
             (in_ch.row_length_bits == DATA_LEN_LONG);
    if (fire) begin
      if (pos_r != POS_MAX) pos_nxt = pos_r + 5'd1;
      if (!in_ch.row_select) begin
        if (pos_r == 5'd0) begin
          pre_len_fault_nxt = 1'b0;
          pre_val_fault_nxt = (in_ch.data_byte != PRE0_VAL_A) &&
                              (in_ch.data_byte != PRE0_VAL_B);
        end else if (pos_r == 5'd1) begin
          if (in_ch.data_byte != PRE1_VAL_A && in_ch.data_byte != PRE1_VAL_B)
            pre_val_fault_nxt = 1'b1;
        end
        if (in_ch.last_byte) begin
          if (pos_r == 5'd0) pre_val_fault_nxt = 1'b1;
          pre_len_fault_nxt = (in_ch.row_length_bits != PRE_LEN_LONG) &&
                              (in_ch.row_length_bits != PRE_LEN_SHORT);
          pos_nxt = '0;
        end
      end else begin
        if (pos_r == 5'd0) begin
          key_base      = '0;
          chk_base      = '0;
          sym_fault_nxt = 1'b0;
        end
        key_nxt = key_base;
        chk_nxt = chk_base;
        if (pos_r < POS_CHK_END) begin
          if (bad_sym) sym_fault_nxt = 1'b1;
          if (pos_r < POS_KEY_END) key_nxt = {key_base[59:0], bits[3], bits[2], bits[1], bits[0]};
          else chk_nxt = {chk_base[11:0], bits[3], bits[2], bits[1], bits[0]};
        end
        if (in_ch.last_byte) begin
          if (pos_r < POS_LAST_MIN) sym_fault_nxt = 1'b1;
          pos_nxt    = '0;
          push_valid = 1'b1;
          if (pre_len_fault_r)    push_data.status = STATUS_LEN_ABORT;
          else if (pre_val_fault_r) push_data.status = STATUS_SANITY;
          else if (!len_ok)        push_data.status = STATUS_LEN_ABORT;
          else if (sym_fault_nxt)  push_data.status = STATUS_SANITY;
          else                     push_data.status = STATUS_OK;
          push_data.key_word   = key_nxt;
          push_data.check_word = chk_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r           <= '0;
      chk_r           <= '0;
      pos_r           <= '0;
      sym_fault_r     <= 1'b0;
      pre_len_fault_r <= 1'b0;
      pre_val_fault_r <= 1'b0;
    end else begin
      key_r           <= key_nxt;
      chk_r           <= chk_nxt;
      pos_r           <= pos_nxt;
      sym_fault_r     <= sym_fault_nxt;
      pre_len_fault_r <= pre_len_fault_nxt;
      pre_val_fault_r <= pre_val_fault_nxt;
    end
  end

endmodule

FILE: hw/rtl/kffd_queue.sv
// ----------------------------------------------------------------------------
// kffd_queue
// small job fifo between the front and back parts
// ----------------------------------------------------------------------------
`include "key_fob_frame_decoder_top_defines.svh"

module kffd_queue import kffd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r,    cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    if (do_push && !do_pop)      cnt_nxt = cnt_r + CW'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  `KFFD_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH), "queue count overflow")
  `KFFD_ASSERT_NEXT(a_cnt_up, clk, rst_n, do_push && !do_pop, cnt_r == $past(cnt_r) + CW'(1), "queue count did not rise")
  `KFFD_ASSERT_NEXT(a_cnt_dn, clk, rst_n, do_pop && !do_push, cnt_r == $past(cnt_r) - CW'(1), "queue count did not fall")

endmodule

FILE: hw/rtl/kffd_back.sv
// ----------------------------------------------------------------------------
// kffd_back
// unscrambles the key of a job into serial, button and count, output register
// ----------------------------------------------------------------------------
module kffd_back import kffd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  job_t      pop_data,
  kffd_out_if.source out_ch
);

  logic        valid_r;
  logic [1:0]  status_r;
  logic [63:0] key_r;
  logic [7:0]  bs_r, crc_r;
  logic [31:0] serial_r;
  logic [3:0]  button_r;
  logic [19:0] count_r;

  logic [7:0]  k [8];
  logic [7:0]  x, lo6, lo7;
  logic        par, ok;

  assign ok = (pop_data.status == STATUS_OK);

  always_comb begin
    for (int i = 0; i < 8; i++) k[i] = pop_data.key_word[63 - 8*i -: 8];
    par = ^pop_data.check_word[15:8];
    x   = par ? k[7] : k[6];
    for (int i = 1; i < 6; i++) k[i] = k[i] ^ x;
    if (par) k[6] = k[6] ^ x;
    else     k[7] = k[7] ^ x;
    lo7 = (k[7] & 8'hAA) | (k[6] & 8'h55);
    lo6 = (k[6] & 8'hAA) | (k[7] & 8'h55);
  end

  assign pop_ready = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop_ready) begin
      valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      status_r <= pop_data.status;
      key_r    <= ok ? pop_data.key_word : '0;
      bs_r     <= ok ? pop_data.check_word[15:8] : '0;
      crc_r    <= ok ? pop_data.check_word[7:0] : '0;
      serial_r <= ok ? {k[1], k[2], k[3], k[4]} : '0;
      button_r <= ok ? k[5][7:4] : '0;
      count_r  <= ok ? {k[5][3:0], lo6, lo7} : '0;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.key_word      = key_r;
  assign out_ch.bs_byte       = bs_r;
  assign out_ch.crc_byte      = crc_r;
  assign out_ch.serial_number = serial_r;
  assign out_ch.button_code   = button_r;
  assign out_ch.rolling_count = count_r;

endmodule

FILE: hw/rtl/key_fob_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// key_fob_frame_decoder_top
// manchester decode of a key fob frame with key unscrambling
// ----------------------------------------------------------------------------
// in_ch carries one row byte per transfer: a preamble row, then a data row,
// last_byte marking the end of each row and row_length_bits valid there.
// out_ch carries one decoded frame per data row, with status, key, check
// bytes and the unscrambled serial, button and rolling count fields.
// throughput: one byte per cycle while the job queue has room, set by the
// combinational symbol decoder in the front part.
// a finished frame is written into the job queue, then into the output
// register, which drives out_ch.
// reset clears row position, fault flags, queue and output valid; until a
// preamble row arrives the preamble is taken as good.
// when out_ch stalls, finished frames collect in the job queue (QUEUE_DEPTH
// entries plus the output register); in_ch drops ready only when the queue
// is full.
// ----------------------------------------------------------------------------
module key_fob_frame_decoder_top import kffd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  kffd_in_if.sink     in_ch,
  kffd_out_if.source  out_ch
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_data, pop_data;

  kffd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  kffd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  kffd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the key fob frame decoder: row bytes go in over
// in_ch, decoded frames are checked field by field on out_ch against an
// in-bench decoder model, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module tb import kffd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit        ROW_PRE      = 1'b0;
  localparam bit        ROW_DATA     = 1'b1;
  localparam logic [1:0] SYM_BAD_LO  = 2'b00;
  localparam logic [1:0] SYM_BAD_HI  = 2'b11;
  localparam int        BYTES_WANTED = 700;
  localparam int        CALM_FROM    = 620;
  localparam int        STUCK_LIMIT  = 2000;
  localparam int        DRAIN_CYCLES = 10;

  typedef struct packed {
    logic       sel;
    logic [7:0] len;
    logic [7:0] data;
    logic       last;
  } row_byte_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] key;
    logic [7:0]  bs;
    logic [7:0]  crc;
    logic [31:0] serial;
    logic [3:0]  button;
    logic [19:0] count;
  } frame_t;

  typedef struct packed {
    row_byte_t b;
    logic      typed;
    status_t   st;
  } dir_row_t;

  logic clk;
  logic rst_n;

  kffd_in_if  in_ch();
  kffd_out_if out_ch();

  key_fob_frame_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // decoder model state
  logic [63:0] key_sr;
  logic [15:0] chk_sr;
  logic [4:0]  row_pos;
  logic        sym_flt;
  logic        pre_len_flt;
  logic        pre_val_flt;

  frame_t   frames_due[$];
  dir_row_t dir_rows[$];

  int  bytes_sent;
  int  frames_predicted;
  int  mismatches;
  int  n_ok;
  int  n_len_abort;
  int  n_sanity;
  bit  idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit decode_byte(input row_byte_t b, output frame_t f);
    logic [4:0] p;
    logic [1:0] sym;
    logic [7:0] k [8];
    logic [7:0] x;
    logic [7:0] lo6;
    logic [7:0] lo7;
    f = '0;
    p = row_pos;
    if (row_pos < POS_MAX) row_pos++;
    if (b.sel == ROW_PRE) begin
      if (p == 5'd0) begin
        pre_len_flt = 1'b0;
        pre_val_flt = 1'b0;
        if (b.data != PRE0_VAL_A && b.data != PRE0_VAL_B) pre_val_flt = 1'b1;
      end else if (p == 5'd1) begin
        if (b.data != PRE1_VAL_A && b.data != PRE1_VAL_B) pre_val_flt = 1'b1;
      end
      if (b.last) begin
        if (p < 5'd1) pre_val_flt = 1'b1;
        pre_len_flt = (b.len != PRE_LEN_LONG && b.len != PRE_LEN_SHORT);
        row_pos = '0;
      end
      return 1'b0;
    end
    if (p == 5'd0) begin
      key_sr = '0;
      chk_sr = '0;
      sym_flt = 1'b0;
    end
    if (p < POS_CHK_END) begin
      for (int s = 3; s >= 0; s--) begin
        sym = b.data[2*s +: 2];
        if (sym != SYM_ONE && sym != SYM_ZERO) sym_flt = 1'b1;
        if (p < POS_KEY_END) key_sr = {key_sr[62:0], sym == SYM_ONE};
        else chk_sr = {chk_sr[14:0], sym == SYM_ONE};
      end
    end
    if (!b.last) return 1'b0;
    if (p < POS_LAST_MIN) sym_flt = 1'b1;
    row_pos = '0;
    if (pre_len_flt) f.status = STATUS_LEN_ABORT;
    else if (pre_val_flt) f.status = STATUS_SANITY;
    else if (b.len != DATA_LEN_SHORT && b.len != DATA_LEN_LONG) f.status = STATUS_LEN_ABORT;
    else if (sym_flt) f.status = STATUS_SANITY;
    else begin
      f.status = STATUS_OK;
      f.key = key_sr;
      f.bs = chk_sr[15:8];
      f.crc = chk_sr[7:0];
      for (int i = 0; i < 8; i++) k[i] = key_sr[63-8*i -: 8];
      // xor sweep keyed on check byte parity
      if (^chk_sr[15:8]) begin
        x = k[7];
        for (int i = 1; i < 7; i++) k[i] ^= x;
      end else begin
        x = k[6];
        for (int i = 1; i < 6; i++) k[i] ^= x;
        k[7] ^= x;
      end
      lo7 = (k[7] & 8'hAA) | (k[6] & 8'h55);
      lo6 = (k[6] & 8'hAA) | (k[7] & 8'h55);
      f.serial = {k[1], k[2], k[3], k[4]};
      f.button = k[5][7:4];
      f.count = {k[5][3:0], lo6, lo7};
    end
    return 1'b1;
  endfunction

  task automatic send_byte(input row_byte_t b, input logic typed, input status_t st);
    frame_t f;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.row_select <= b.sel;
    in_ch.row_length_bits <= b.len;
    in_ch.data_byte <= b.data;
    in_ch.last_byte <= b.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    if (decode_byte(b, f)) begin
      if (typed) begin
        f = '0;
        f.status = st;
      end
      frames_due.push_back(f);
      frames_predicted++;
    end
  endtask

  function automatic logic [7:0] pick2(input logic [7:0] a, input logic [7:0] c);
    return $urandom_range(0, 1) ? a : c;
  endfunction

  function automatic logic [7:0] sym_byte();
    logic [7:0] v;
    for (int s = 0; s < 4; s++) v[2*s +: 2] = $urandom_range(0, 1) ? SYM_ONE : SYM_ZERO;
    return v;
  endfunction

  function automatic void add_row(input logic sel, input logic [7:0] len,
                                  input logic [7:0] data, input logic last,
                                  input logic typed, input status_t st);
    dir_row_t r;
    r.b = '{sel: sel, len: len, data: data, last: last};
    r.typed = typed;
    r.st = st;
    dir_rows.push_back(r);
  endfunction

  task automatic send_preamble(input bit good);
    row_byte_t b;
    int kind;
    int n;
    logic [7:0] plen;
    kind = $urandom_range(0, 3);
    n = (!good && kind == 3) ? 1 : $urandom_range(2, 5);
    plen = (good || kind != 2) ? pick2(PRE_LEN_LONG, PRE_LEN_SHORT) : 8'($urandom);
    for (int i = 0; i < n; i++) begin
      b.sel = ROW_PRE;
      b.last = (i == n - 1);
      b.len = b.last ? plen : 8'($urandom);
      if (i == 0) b.data = (good || kind != 0) ? pick2(PRE0_VAL_A, PRE0_VAL_B) : 8'($urandom);
      else if (i == 1) b.data = (good || kind != 1) ? pick2(PRE1_VAL_A, PRE1_VAL_B)
                                                    : 8'($urandom);
      else b.data = 8'($urandom);
      send_byte(b, 1'b0, STATUS_OK);
    end
  endtask

  // broken kinds: bad symbol, short row, bad length, overlong row, select flip
  task automatic send_data(input bit good);
    row_byte_t b;
    int kind;
    int n;
    int bad_at;
    kind = good ? 0 : $urandom_range(1, 5);
    n = (kind == 2) ? $urandom_range(1, 19) :
        (kind == 4) ? $urandom_range(33, 40) : $urandom_range(20, 23);
    bad_at = $urandom_range(0, 19);
    for (int i = 0; i < n; i++) begin
      b.sel = ROW_DATA;
      b.last = (i == n - 1);
      b.data = (i < 20) ? sym_byte() : 8'($urandom);
      if (kind == 1 && i == bad_at)
        b.data[2*$urandom_range(0, 3) +: 2] = $urandom_range(0, 1) ? SYM_BAD_LO : SYM_BAD_HI;
      if (kind == 5 && i == bad_at && !b.last) b.sel = ROW_PRE;
      if (!b.last) b.len = 8'($urandom);
      else if (kind == 3) b.len = 8'($urandom);
      else b.len = pick2(DATA_LEN_SHORT, DATA_LEN_LONG);
      send_byte(b, 1'b0, STATUS_OK);
    end
  endtask

  function automatic void cmp_field(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // result sink with stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 6);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frame_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (frames_due.size() == 0) begin
        mismatches++;
        $display("%0t: frame with no expectation, status %0d", $time, out_ch.status);
      end else begin
        want = frames_due.pop_front();
        cmp_field("status", 64'(want.status), 64'(out_ch.status));
        cmp_field("key_word", want.key, out_ch.key_word);
        cmp_field("bs_byte", 64'(want.bs), 64'(out_ch.bs_byte));
        cmp_field("crc_byte", 64'(want.crc), 64'(out_ch.crc_byte));
        cmp_field("serial_number", 64'(want.serial), 64'(out_ch.serial_number));
        cmp_field("button_code", 64'(want.button), 64'(out_ch.button_code));
        cmp_field("rolling_count", 64'(want.count), 64'(out_ch.rolling_count));
        case (want.status)
          STATUS_OK:        n_ok++;
          STATUS_LEN_ABORT: n_len_abort++;
          default:          n_sanity++;
        endcase
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
    $display("key_fob_frame_decoder_top test failed");
    $finish;
  end

  initial begin
    logic [7:0] good_bytes [20];
    int pick;
    int frame_idx;
    good_bytes = '{8'h55, 8'hAA, 8'h56, 8'h65, 8'h59, 8'h95, 8'h5A,
                   8'hA5, 8'h66, 8'h99, 8'h69, 8'h96, 8'h6A, 8'hA6,
                   8'h9A, 8'hA9, 8'h65, 8'h9A, 8'h56, 8'hA9};
    key_sr = '0;
    chk_sr = '0;
    row_pos = '0;
    sym_flt = 1'b0;
    pre_len_flt = 1'b0;
    pre_val_flt = 1'b0;
    bytes_sent = 0;
    frames_predicted = 0;
    mismatches = 0;
    n_ok = 0;
    n_len_abort = 0;
    n_sanity = 0;
    idle_on = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.row_select <= ROW_PRE;
    in_ch.row_length_bits <= '0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short data row straight after reset: preamble taken as good
    add_row(ROW_DATA, DATA_LEN_SHORT, 8'h55, 1'b1, 1'b1, STATUS_SANITY);
    // preamble row ending before its second byte
    add_row(ROW_PRE, PRE_LEN_SHORT, PRE0_VAL_B, 1'b1, 1'b0, STATUS_OK);
    add_row(ROW_DATA, DATA_LEN_LONG, 8'hAA, 1'b1, 1'b1, STATUS_SANITY);
    // bad preamble length and value
    add_row(ROW_PRE, 8'd0, 8'h00, 1'b1, 1'b0, STATUS_OK);
    add_row(ROW_DATA, 8'd255, 8'hFF, 1'b1, 1'b1, STATUS_LEN_ABORT);
    // full good frame
    add_row(ROW_PRE, 8'hFF, PRE0_VAL_A, 1'b0, 1'b0, STATUS_OK);
    add_row(ROW_PRE, PRE_LEN_LONG, PRE1_VAL_A, 1'b1, 1'b0, STATUS_OK);
    for (int i = 0; i < 20; i++)
      add_row(ROW_DATA, (i == 19) ? DATA_LEN_LONG : 8'($urandom), good_bytes[i],
              i == 19, 1'b0, STATUS_OK);

    idle_on = 1'b1;
    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].st);

    frame_idx = 0;
    while (bytes_sent < BYTES_WANTED) begin
      idle_on = (bytes_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      if (frame_idx % 10 == 3) begin
        // hold off until the decoder has drained
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (frames_due.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 4) != 0) send_preamble(1'b1);
        send_data(1'b1);
      end else if (pick < 90) begin
        if ($urandom_range(0, 3) != 0) send_preamble(1'($urandom_range(0, 1)));
        send_data(1'b0);
      end else begin
        repeat ($urandom_range(1, 8))
          send_byte('{sel: 1'($urandom_range(0, 1)), len: 8'($urandom), data: 8'($urandom),
                      last: ($urandom_range(0, 3) == 0)}, 1'b0, STATUS_OK);
      end
      frame_idx++;
    end
    in_ch.valid <= 1'b0;
    idle_on = 1'b0;

    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d row bytes over %0d sequences, %0d frames expected",
             bytes_sent, frame_idx, frames_predicted);
    $display("frames: %0d decoded, %0d length abort, %0d sanity",
             n_ok, n_len_abort, n_sanity);
    if (mismatches == 0) begin
      $display("key_fob_frame_decoder_top test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("key_fob_frame_decoder_top test failed");
    end
    $finish;
  end

endmodule

FILE: key_fob_frame_decoder_top.f
+incdir+hw/rtl
hw/rtl/kffd_pkg.sv
hw/rtl/kffd_if.sv
hw/rtl/kffd_front.sv
hw/rtl/kffd_queue.sv
hw/rtl/kffd_back.sv
hw/rtl/key_fob_frame_decoder_top.sv
tb/tb.sv
